[design/gradient_noise_2d_unit_assert.svh]
// Assertion macros used by the top level of the gradient noise unit.
`ifndef GRADIENT_NOISE_2D_UNIT_ASSERT_SVH
`define GRADIENT_NOISE_2D_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GN2D_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define GN2D_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/gn2d_pkg.sv]
// Package with the constants, types and permutation table of the gradient noise unit.
package gn2d_pkg;

  // Fixed-point layout of the coordinates and the result.
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned COORD_W   = 24;
  localparam int unsigned CELL_W    = 8;
  localparam int unsigned NOISE_W   = 19;
  // Fade result reaches at most one, so it needs one integer bit.
  localparam int unsigned FADE_W    = FRAC_BITS + 1;
  // Corner gradient values lie within minus two to two inclusive, so plus two
  // needs a third integer bit.
  localparam int unsigned GRAD_W    = FRAC_BITS + 3;
  // Register stages from the input to the output register.
  localparam int unsigned N_STAGES  = 5;
  // Stages inside the fade pipeline and the hash pipeline.
  localparam int unsigned FADE_STAGES = 3;
  localparam int unsigned HASH_STAGES = 2;

  typedef logic [CELL_W-1:0]    cell_t;
  typedef logic [FRAC_BITS-1:0] frac_t;
  typedef logic [FADE_W-1:0]    fade_t;
  typedef logic [COORD_W-1:0]   coord_t;
  typedef logic signed [NOISE_W-1:0] noise_t;

  // Diagonal gradient chosen by the two low hash bits.
  typedef enum logic [1:0] {
    GRAD_PX_PZ = 2'd0,
    GRAD_NX_PZ = 2'd1,
    GRAD_PX_NZ = 2'd2,
    GRAD_NX_NZ = 2'd3
  } grad_e;

  // Gradient selections of the four cell corners.
  typedef struct packed {
    grad_e h00;
    grad_e h01;
    grad_e h10;
    grad_e h11;
  } corner_hash_t;

  // Permutation table; it repeats every 256 entries, so 8-bit indexes wrap.
  localparam logic [7:0] PERM [256] = '{
    8'd151, 8'd160, 8'd137, 8'd91,  8'd90,  8'd15,  8'd131, 8'd13,
    8'd201, 8'd95,  8'd96,  8'd53,  8'd194, 8'd233, 8'd7,   8'd225,
    8'd140, 8'd36,  8'd103, 8'd30,  8'd69,  8'd142, 8'd8,   8'd99,
    8'd37,  8'd240, 8'd21,  8'd10,  8'd23,  8'd190, 8'd6,   8'd148,
    8'd247, 8'd120, 8'd234, 8'd75,  8'd0,   8'd26,  8'd197, 8'd62,
    8'd94,  8'd252, 8'd219, 8'd203, 8'd117, 8'd35,  8'd11,  8'd32,
    8'd57,  8'd177, 8'd33,  8'd88,  8'd237, 8'd149, 8'd56,  8'd87,
    8'd174, 8'd20,  8'd125, 8'd136, 8'd171, 8'd168, 8'd68,  8'd175,
    8'd74,  8'd165, 8'd71,  8'd134, 8'd139, 8'd48,  8'd27,  8'd166,
    8'd77,  8'd146, 8'd158, 8'd231, 8'd83,  8'd111, 8'd229, 8'd122,
    8'd60,  8'd211, 8'd133, 8'd230, 8'd220, 8'd105, 8'd92,  8'd41,
    8'd55,  8'd46,  8'd245, 8'd40,  8'd244, 8'd102, 8'd143, 8'd54,
    8'd65,  8'd25,  8'd63,  8'd161, 8'd1,   8'd216, 8'd80,  8'd73,
    8'd209, 8'd76,  8'd132, 8'd187, 8'd208, 8'd89,  8'd18,  8'd169,
    8'd200, 8'd196, 8'd135, 8'd130, 8'd116, 8'd188, 8'd159, 8'd86,
    8'd164, 8'd100, 8'd109, 8'd198, 8'd173, 8'd186, 8'd3,   8'd64,
    8'd52,  8'd217, 8'd226, 8'd250, 8'd124, 8'd123, 8'd5,   8'd202,
    8'd38,  8'd147, 8'd118, 8'd126, 8'd255, 8'd82,  8'd85,  8'd212,
    8'd207, 8'd206, 8'd59,  8'd227, 8'd47,  8'd16,  8'd58,  8'd17,
    8'd182, 8'd189, 8'd28,  8'd42,  8'd223, 8'd183, 8'd170, 8'd213,
    8'd119, 8'd248, 8'd152, 8'd2,   8'd44,  8'd154, 8'd163, 8'd70,
    8'd221, 8'd153, 8'd101, 8'd155, 8'd167, 8'd43,  8'd172, 8'd9,
    8'd129, 8'd22,  8'd39,  8'd253, 8'd19,  8'd98,  8'd108, 8'd110,
    8'd79,  8'd113, 8'd224, 8'd232, 8'd178, 8'd185, 8'd112, 8'd104,
    8'd218, 8'd246, 8'd97,  8'd228, 8'd251, 8'd34,  8'd242, 8'd193,
    8'd238, 8'd210, 8'd144, 8'd12,  8'd191, 8'd179, 8'd162, 8'd241,
    8'd81,  8'd51,  8'd145, 8'd235, 8'd249, 8'd14,  8'd239, 8'd107,
    8'd49,  8'd192, 8'd214, 8'd31,  8'd181, 8'd199, 8'd106, 8'd157,
    8'd184, 8'd84,  8'd204, 8'd176, 8'd115, 8'd121, 8'd50,  8'd45,
    8'd127, 8'd4,   8'd150, 8'd254, 8'd138, 8'd236, 8'd205, 8'd93,
    8'd222, 8'd114, 8'd67,  8'd29,  8'd24,  8'd72,  8'd243, 8'd141,
    8'd128, 8'd195, 8'd78,  8'd66,  8'd215, 8'd61,  8'd156, 8'd180
  };

  // Look up one permutation entry.
  function automatic cell_t perm_lookup(cell_t idx);
    return cell_t'(PERM[idx]);
  endfunction

endpackage

[design/gn2d_if.sv]
// Valid/ready channel interfaces for sample points and noise results.
interface gn2d_pt_if;
  import gn2d_pkg::*;

  logic   valid;
  logic   ready;
  coord_t x_coord;
  coord_t z_coord;

  modport source (output valid, output x_coord, output z_coord, input ready);
  modport sink   (input valid, input x_coord, input z_coord, output ready);
endinterface

interface gn2d_res_if;
  import gn2d_pkg::*;

  logic   valid;
  logic   ready;
  noise_t noise_value;

  modport source (output valid, output noise_value, input ready);
  modport sink   (input valid, input noise_value, output ready);
endinterface

[design/gn2d_fade.sv]
// Three-stage pipeline computing the quintic fade 6t^5-15t^4+10t^3 of a fraction.
module gn2d_fade (
  input  logic                                clk_i,
  input  logic [gn2d_pkg::FADE_STAGES-1:0]    en_i,
  input  gn2d_pkg::frac_t                     t_i,
  output gn2d_pkg::fade_t                     u_o
);
  import gn2d_pkg::*;

  // Width of the signed linear term 6t - 15 and of the quadratic term.
  localparam int unsigned LIN_W   = FRAC_BITS + 6;
  localparam int unsigned PROD_W  = 2 * LIN_W;
  // The inner polynomial reaches at most ten, so four integer bits do.
  localparam int unsigned INNER_W = FRAC_BITS + 4;
  localparam logic signed [LIN_W-1:0]  FIFTEEN_ONE = LIN_W'(15) << FRAC_BITS;
  localparam logic signed [PROD_W-1:0] TEN_ONE     = PROD_W'(10) << FRAC_BITS;

  logic signed [LIN_W-1:0]    t_s;
  logic signed [LIN_W-1:0]    lin;
  logic signed [PROD_W-1:0]   quad_prod;
  logic signed [PROD_W-1:0]   inner_sum;
  logic [2*FRAC_BITS-1:0]     sq_prod;
  logic [2*FRAC_BITS-1:0]     cube_prod;
  logic [INNER_W+FRAC_BITS-1:0] fade_prod;

  frac_t                t1_q, t2_q, t3_d, t3_q;
  logic [INNER_W-1:0]   inner_d, inner1_q, inner2_q;
  frac_t                t_sq_d;
  fade_t                u_d, u_q;

  // First stage: t squared and the inner polynomial t*(6t-15)+10.
  always_comb begin
    t_s       = signed'(LIN_W'(t_i));
    lin       = (t_s <<< 2) + (t_s <<< 1) - FIFTEEN_ONE;
    quad_prod = PROD_W'(t_s) * PROD_W'(lin);
    inner_sum = (quad_prod >>> FRAC_BITS) + TEN_ONE;
    inner_d   = inner_sum[INNER_W-1:0];
    sq_prod   = (2*FRAC_BITS)'(t_i) * (2*FRAC_BITS)'(t_i);
    t_sq_d    = sq_prod[2*FRAC_BITS-1:FRAC_BITS];
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      t1_q     <= t_i;
      t2_q     <= t_sq_d;
      inner1_q <= inner_d;
    end
  end

  // Second stage: t cubed.
  always_comb begin
    cube_prod = (2*FRAC_BITS)'(t2_q) * (2*FRAC_BITS)'(t1_q);
    t3_d      = cube_prod[2*FRAC_BITS-1:FRAC_BITS];
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      t3_q     <= t3_d;
      inner2_q <= inner1_q;
    end
  end

  // Third stage: t cubed times the inner polynomial.
  always_comb begin
    fade_prod = (INNER_W+FRAC_BITS)'(t3_q) * (INNER_W+FRAC_BITS)'(inner2_q);
    u_d       = fade_prod[FRAC_BITS+FADE_W-1:FRAC_BITS];
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      u_q <= u_d;
    end
  end

  assign u_o = u_q;

endmodule

[design/gn2d_hash.sv]
// Two-stage permutation lookup that yields the gradient selection of each cell corner.
module gn2d_hash (
  input  logic                              clk_i,
  input  logic [gn2d_pkg::HASH_STAGES-1:0]  en_i,
  input  gn2d_pkg::cell_t                   ix_i,
  input  gn2d_pkg::cell_t                   iz_i,
  output gn2d_pkg::corner_hash_t            hash_o
);
  import gn2d_pkg::*;

  cell_t        px0_q, px1_q, iz_q;
  cell_t        iz_next;
  cell_t        h00, h01, h10, h11;
  corner_hash_t hash_d, hash_q;

  // First lookup on the x cell and its right neighbor.
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      px0_q <= perm_lookup(ix_i);
      px1_q <= perm_lookup(ix_i + cell_t'(1));
      iz_q  <= iz_i;
    end
  end

  // Second lookup adds the z cell; all sums wrap modulo the table size.
  always_comb begin
    iz_next    = iz_q + cell_t'(1);
    h00        = perm_lookup(px0_q + iz_q);
    h01        = perm_lookup(px0_q + iz_next);
    h10        = perm_lookup(px1_q + iz_q);
    h11        = perm_lookup(px1_q + iz_next);
    hash_d.h00 = grad_e'(h00[1:0]);
    hash_d.h01 = grad_e'(h01[1:0]);
    hash_d.h10 = grad_e'(h10[1:0]);
    hash_d.h11 = grad_e'(h11[1:0]);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      hash_q <= hash_d;
    end
  end

  assign hash_o = hash_q;

endmodule

[design/gn2d_lerp.sv]
// Registered linear blend a + floor((b-a)*w) with a fractional weight.
module gn2d_lerp #(
  parameter int unsigned IN_W  = 18,
  parameter int unsigned OUT_W = 19
) (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic signed [IN_W-1:0]  a_i,
  input  logic signed [IN_W-1:0]  b_i,
  input  gn2d_pkg::fade_t         w_i,
  output logic signed [OUT_W-1:0] y_o
);
  import gn2d_pkg::*;

  localparam int unsigned DIFF_W = IN_W + 1;
  localparam int unsigned PROD_W = DIFF_W + FADE_W + 1;

  logic signed [DIFF_W-1:0] diff;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] sum;
  logic signed [OUT_W-1:0]  y_d, y_q;

  // The arithmetic shift rounds the scaled difference toward minus infinity.
  always_comb begin
    diff = DIFF_W'(b_i) - DIFF_W'(a_i);
    prod = PROD_W'(diff) * signed'(PROD_W'(w_i));
    sum  = (prod >>> FRAC_BITS) + PROD_W'(a_i);
    y_d  = sum[OUT_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      y_q <= y_d;
    end
  end

  assign y_o = y_q;

endmodule

[design/gradient_noise_2d_unit.sv]
// Top level of the 2D gradient noise unit: stage control, corner gradients and blends.
//
//   Channel   Dir   Word                     Handshake
//   pt_i      in    x_coord, z_coord (Q8.16)  valid/ready
//   res_o     out   noise_value (Q2.16)       valid/ready
//
// Every point passes five register stages on its way to the output register,
// and a new point is accepted every cycle unless the full pipeline is held by
// a stalled output. The depth is set by the fade chain: three multiplies
// in series, then the two blend multiplies along x and along z.
// Reset clears only the stage valid bits. A stalled output holds its word and
// the stages behind it fill their empty slots before the input is held off.
module gradient_noise_2d_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  gn2d_pt_if.sink    pt_i,
  gn2d_res_if.source res_o
);
  import gn2d_pkg::*;

  localparam logic signed [GRAD_W-1:0] ONE_G = GRAD_W'(1) << FRAC_BITS;
  localparam logic signed [NOISE_W-1:0] NOISE_MAX = NOISE_W'(2) << FRAC_BITS;

  logic [N_STAGES-1:0] valid_q;
  logic [N_STAGES-1:0] en;

  frac_t fx0_q, fz0_q, fx1_q, fz1_q;
  fade_t u_w, v_w, v3_q;
  corner_hash_t hash_w;

  logic signed [GRAD_W-1:0] dx0, dx1, dz0, dz1;
  logic signed [GRAD_W-1:0] g00_d, g01_d, g10_d, g11_d;
  logic signed [GRAD_W-1:0] g00_q, g01_q, g10_q, g11_q;
  logic signed [NOISE_W-1:0] r0_w, r1_w, noise_w;

  // Gradient dot product for one of the four diagonal directions.
  function automatic logic signed [GRAD_W-1:0] corner_grad(
    grad_e                    h,
    logic signed [GRAD_W-1:0] dx,
    logic signed [GRAD_W-1:0] dz
  );
    logic signed [GRAD_W-1:0] g;
    case (h)
      GRAD_PX_PZ: g = dx + dz;
      GRAD_NX_PZ: g = dz - dx;
      GRAD_PX_NZ: g = dx - dz;
      GRAD_NX_NZ: g = -dx - dz;
      default:    g = '0;
    endcase
    return g;
  endfunction

  // A stage loads when it is empty or when the stage after it moves on.
  always_comb begin
    en[N_STAGES-1] = !valid_q[N_STAGES-1] || res_o.ready;
    for (int k = N_STAGES - 2; k >= 0; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
  end

  // Valid bits travel with the words.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (en[0]) begin
        valid_q[0] <= pt_i.valid;
      end
      for (int k = 1; k < N_STAGES; k++) begin
        if (en[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
    end
  end

  assign pt_i.ready  = en[0];
  assign res_o.valid = valid_q[N_STAGES-1];

  // Fade curves of both fractions.
  gn2d_fade u_fade_x (
    .clk_i (clk_i),
    .en_i  (en[FADE_STAGES-1:0]),
    .t_i   (pt_i.x_coord[FRAC_BITS-1:0]),
    .u_o   (u_w)
  );

  gn2d_fade u_fade_z (
    .clk_i (clk_i),
    .en_i  (en[FADE_STAGES-1:0]),
    .t_i   (pt_i.z_coord[FRAC_BITS-1:0]),
    .u_o   (v_w)
  );

  // Corner hashes of the lattice cell.
  gn2d_hash u_hash (
    .clk_i  (clk_i),
    .en_i   (en[HASH_STAGES-1:0]),
    .ix_i   (pt_i.x_coord[FRAC_BITS+CELL_W-1:FRAC_BITS]),
    .iz_i   (pt_i.z_coord[FRAC_BITS+CELL_W-1:FRAC_BITS]),
    .hash_o (hash_w)
  );

  // Fractions follow the hash pipeline to the gradient stage.
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      fx0_q <= pt_i.x_coord[FRAC_BITS-1:0];
      fz0_q <= pt_i.z_coord[FRAC_BITS-1:0];
    end
    if (en[1]) begin
      fx1_q <= fx0_q;
      fz1_q <= fz0_q;
    end
  end

  // Corner offsets and gradient values.
  always_comb begin
    dx0   = signed'(GRAD_W'(fx1_q));
    dz0   = signed'(GRAD_W'(fz1_q));
    dx1   = dx0 - ONE_G;
    dz1   = dz0 - ONE_G;
    g00_d = corner_grad(hash_w.h00, dx0, dz0);
    g10_d = corner_grad(hash_w.h10, dx1, dz0);
    g01_d = corner_grad(hash_w.h01, dx0, dz1);
    g11_d = corner_grad(hash_w.h11, dx1, dz1);
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      g00_q <= g00_d;
      g01_q <= g01_d;
      g10_q <= g10_d;
      g11_q <= g11_d;
    end
    if (en[3]) begin
      v3_q <= v_w;
    end
  end

  // Blend along x for the near and the far row.
  gn2d_lerp #(
    .IN_W  (GRAD_W),
    .OUT_W (NOISE_W)
  ) u_lerp_r0 (
    .clk_i (clk_i),
    .en_i  (en[3]),
    .a_i   (g00_q),
    .b_i   (g10_q),
    .w_i   (u_w),
    .y_o   (r0_w)
  );

  gn2d_lerp #(
    .IN_W  (GRAD_W),
    .OUT_W (NOISE_W)
  ) u_lerp_r1 (
    .clk_i (clk_i),
    .en_i  (en[3]),
    .a_i   (g01_q),
    .b_i   (g11_q),
    .w_i   (u_w),
    .y_o   (r1_w)
  );

  // Blend along z into the output register.
  gn2d_lerp #(
    .IN_W  (NOISE_W),
    .OUT_W (NOISE_W)
  ) u_lerp_n (
    .clk_i (clk_i),
    .en_i  (en[4]),
    .a_i   (r0_w),
    .b_i   (r1_w),
    .w_i   (v3_q),
    .y_o   (noise_w)
  );

  assign res_o.noise_value = noise_w;

  // Checks on the stage control and the result range.
`include "gradient_noise_2d_unit_assert.svh"

  `GN2D_ASSERT_NOW(a_stall_only_when_full, clk_i, rst_ni, !pt_i.ready, &valid_q, "input held off with an empty stage")
  `GN2D_ASSERT_NEXT(a_accept_fills_stage, clk_i, rst_ni, pt_i.valid && pt_i.ready, valid_q[0], "accepted point did not enter the first stage")
  `GN2D_ASSERT_NEXT(a_advance_to_output, clk_i, rst_ni, valid_q[N_STAGES-2] && en[N_STAGES-1], res_o.valid, "word lost before the output register")
  `GN2D_ASSERT_NOW(a_noise_range, clk_i, rst_ni, res_o.valid, (res_o.noise_value <= NOISE_MAX) && (res_o.noise_value >= -NOISE_MAX), "noise value outside minus two to two")

endmodule

[tb/gradient_noise_2d_unit_tb.sv]
// Self-checking testbench of the 2D gradient noise unit.
`timescale 1ns / 1ps

module gradient_noise_2d_unit_tb;
  import gn2d_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned HOLD_CYCLES = 60;
  localparam int unsigned MAX_REPORTS = 10;

  // One point in flight and the noise it must produce.
  typedef struct {
    coord_t x;
    coord_t z;
    noise_t noise;
  } pending_noise_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  gn2d_pt_if  pt_if();
  gn2d_res_if res_if();

  pending_noise_t pending_noise[$];
  int unsigned    error_count = 0;
  int unsigned    cycle_count = 0;
  bit             gaps_on     = 1'b1;
  bit             stalls_on   = 1'b1;
  bit             hold_req    = 1'b0;

  gradient_noise_2d_unit u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pt_i   (pt_if),
    .res_o  (res_if)
  );

  always #6 clk_i = ~clk_i;

  // Q.F product, rounded toward minus infinity.
  function automatic longint fixmul(longint a, longint b);
    return (a * b) >>> FRAC_BITS;
  endfunction

  // Quintic fade 6t^5 - 15t^4 + 10t^3 in the same product order as the block.
  function automatic longint fade_curve(longint t);
    longint one;
    longint t3;
    longint inner;
    one   = longint'(1) << FRAC_BITS;
    t3    = fixmul(fixmul(t, t), t);
    inner = fixmul(t, 6 * t - 15 * one) + 10 * one;
    return fixmul(t3, inner);
  endfunction

  // Dot product of a diagonal gradient with the corner offset.
  function automatic longint corner_value(grad_e g, longint dx, longint dz);
    case (g)
      GRAD_PX_PZ: return dx + dz;
      GRAD_NX_PZ: return -dx + dz;
      GRAD_PX_NZ: return dx - dz;
      default:    return -dx - dz;
    endcase
  endfunction

  function automatic longint lerp_q(longint a, longint b, longint w);
    return a + fixmul(b - a, w);
  endfunction

  // Expected noise word for one sample point.
  function automatic noise_t noise_at(coord_t x, coord_t z);
    longint one;
    longint fx;
    longint fz;
    longint u;
    longint v;
    longint r0;
    longint r1;
    cell_t  ix;
    cell_t  iz;
    cell_t  px0;
    cell_t  px1;
    grad_e  g00;
    grad_e  g01;
    grad_e  g10;
    grad_e  g11;
    one = longint'(1) << FRAC_BITS;
    ix  = x[COORD_W-1 -: CELL_W];
    iz  = z[COORD_W-1 -: CELL_W];
    fx  = longint'(x[FRAC_BITS-1:0]);
    fz  = longint'(z[FRAC_BITS-1:0]);
    u   = fade_curve(fx);
    v   = fade_curve(fz);
    // Corner hashes; all cell sums wrap at eight bits.
    px0 = PERM[ix];
    px1 = PERM[cell_t'(ix + 8'd1)];
    g00 = grad_e'(PERM[cell_t'(px0 + iz)][1:0]);
    g01 = grad_e'(PERM[cell_t'(px0 + iz + 8'd1)][1:0]);
    g10 = grad_e'(PERM[cell_t'(px1 + iz)][1:0]);
    g11 = grad_e'(PERM[cell_t'(px1 + iz + 8'd1)][1:0]);
    // Blend along x on both z rows, then along z.
    r0 = lerp_q(corner_value(g00, fx, fz), corner_value(g10, fx - one, fz), u);
    r1 = lerp_q(corner_value(g01, fx, fz - one),
                corner_value(g11, fx - one, fz - one), u);
    return noise_t'(lerp_q(r0, r1, v));
  endfunction

  // Random coordinate that leans toward cell and fraction edges.
  function automatic coord_t rand_coord();
    frac_t f;
    cell_t c;
    case ($urandom_range(0, 7))
      0:       f = '0;
      1:       f = '1;
      2:       f = frac_t'($urandom_range(0, 15));
      3:       f = frac_t'(16'hFFFF - $urandom_range(0, 15));
      default: f = frac_t'($urandom);
    endcase
    case ($urandom_range(0, 7))
      0:       c = '0;
      1:       c = '1;
      default: c = cell_t'($urandom);
    endcase
    return {c, f};
  endfunction

  // Offer one point, with an optional idle burst first, and wait for its handshake.
  // Valid stays high afterwards; the next gap, a drain pause or the end of the run lowers it.
  task automatic send_point(coord_t x, coord_t z);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      pt_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    pt_if.valid   <= 1'b1;
    pt_if.x_coord <= x;
    pt_if.z_coord <= z;
    @(posedge clk_i);
    while (!pt_if.ready) @(posedge clk_i);
    pending_noise.push_back('{x: x, z: z, noise: noise_at(x, z)});
  endtask

  // Corners of the coordinate range, cell wrap and every gradient direction.
  task automatic test_directed_points();
    cell_t ix;
    cell_t iz;
    cell_t px0;
    cell_t px1;
    bit    near_found;
    bit    far_found;
    send_point(24'h000000, 24'h000000);
    send_point(24'hFFFFFF, 24'hFFFFFF);
    send_point(24'hFFFFFF, 24'h000000);
    send_point(24'h000000, 24'hFFFFFF);
    send_point(24'h00FFFF, 24'h00FFFF);
    send_point(24'h008000, 24'h008000);
    send_point(24'h000001, 24'h000001);
    send_point(24'hFF8000, 24'hFF8000);
    send_point(24'hFF0000, 24'hFF0000);
    send_point(24'hAA5555, 24'h55AAAA);
    send_point(24'h55AAAA, 24'hAA5555);
    // For each gradient, one cell where it sits at the near corner and one
    // where it sits at the far corner; the fraction puts the point next to it.
    for (int g = 0; g < 4; g++) begin
      near_found = 1'b0;
      far_found  = 1'b0;
      for (int c = 0; c < 65536; c++) begin
        ix  = cell_t'(c >> 8);
        iz  = cell_t'(c);
        px0 = PERM[ix];
        px1 = PERM[cell_t'(ix + 8'd1)];
        if (!near_found && PERM[cell_t'(px0 + iz)][1:0] == g[1:0]) begin
          near_found = 1'b1;
          send_point({ix, 16'h0100}, {iz, 16'h0100});
        end
        if (!far_found && PERM[cell_t'(px1 + iz + 8'd1)][1:0] == g[1:0]) begin
          far_found = 1'b1;
          send_point({ix, 16'hFF00}, {iz, 16'hFF00});
        end
        if (near_found && far_found) break;
      end
    end
  endtask

  // Random points; idling on both sides is switched on and off in stretches.
  task automatic test_random_points(int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      if (i % 100 == 0) begin
        gaps_on   = ($urandom_range(0, 3) != 0);
        stalls_on = ($urandom_range(0, 3) != 0);
      end
      send_point(rand_coord(), rand_coord());
    end
  endtask

  // The result side holds off for a long stretch while points keep coming,
  // so the pipeline fills and the input is held off.
  task automatic test_output_hold();
    gaps_on   = 1'b0;
    stalls_on = 1'b1;
    hold_req  = 1'b1;
    for (int i = 0; i < 60; i++) send_point(rand_coord(), rand_coord());
  endtask

  // The sender stops until every pending result has come back, then resumes.
  task automatic test_drain_pause();
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    for (int r = 0; r < 2; r++) begin
      for (int i = 0; i < 100; i++) send_point(rand_coord(), rand_coord());
      pt_if.valid <= 1'b0;
      @(posedge clk_i);
      while (pending_noise.size() != 0) @(posedge clk_i);
    end
  endtask

  // Back-to-back points with the result side always ready.
  task automatic test_full_rate(int unsigned n);
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    for (int unsigned i = 0; i < n; i++) send_point(rand_coord(), rand_coord());
  endtask

  // Result side ready: random stall bursts and the requested long hold.
  initial begin
    res_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        res_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else if (stalls_on && $urandom_range(0, 7) == 0) begin
        res_if.ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end else begin
        res_if.ready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  // Compare every accepted noise word with the oldest pending one.
  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (pending_noise.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("unexpected noise word %0d with no point pending",
                   res_if.noise_value);
      end else begin
        if (res_if.noise_value !== pending_noise[0].noise) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("noise mismatch at x=%h z=%h: expected %0d, got %0d",
                     pending_noise[0].x, pending_noise[0].z,
                     pending_noise[0].noise, res_if.noise_value);
        end
        void'(pending_noise.pop_front());
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Reset, the test sequence and the final verdict.
  initial begin
    rst_ni        <= 1'b0;
    pt_if.valid   <= 1'b0;
    pt_if.x_coord <= '0;
    pt_if.z_coord <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_points();
    test_output_hold();
    test_random_points(1000);
    test_drain_pause();
    test_full_rate(670);

    pt_if.valid <= 1'b0;
    while (pending_noise.size() != 0) @(posedge clk_i);
    repeat (4 * N_STAGES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+design
design/gn2d_pkg.sv
design/gn2d_if.sv
design/gn2d_fade.sv
design/gn2d_hash.sv
design/gn2d_lerp.sv
design/gradient_noise_2d_unit.sv
tb/gradient_noise_2d_unit_tb.sv
